>>> src/rod_pkg.sv
// rod_pkg: shared types, codes and constants of the region occupancy debouncer
// no dependencies; imported by rod_ctrl, rod_datapath and region_occupancy_debouncer_core
package rod_pkg;

    typedef struct packed {
        logic        req_type;
        logic [4:0]  slot_index;
        logic [7:0]  region_number;
        logic [8:0]  region_width;
        logic [7:0]  region_height;
        logic [15:0] red_changed;
        logic [15:0] green_changed;
        logic [15:0] blue_changed;
    } t_req;

    typedef struct packed {
        logic       found;
        logic [2:0] region_state;
    } t_result;

    localparam logic REQ_LOAD = 1'b0;
    localparam logic REQ_EVAL = 1'b1;

    localparam logic CFG_ACTIVE_SLOTS     = 1'b0;
    localparam logic CFG_TRANSITION_LIMIT = 1'b1;

    localparam logic [5:0] ACTIVE_SLOTS_RESET     = 6'd0;
    localparam logic [5:0] TRANSITION_LIMIT_RESET = 6'd20;
    localparam logic [5:0] COUNT_MAX              = 6'd63;

    // x / 3 == (x * 43691) >> 17 for every 16-bit x
    localparam logic [15:0] RECIP3       = 16'd43691;
    localparam int          RECIP3_SHIFT = 17;

    localparam logic [2:0] STATE_NONE = 3'd0;

    typedef enum logic [1:0] {
        PH_FREE     = 2'd0,
        PH_ENTERING = 2'd1,
        PH_OCCUPIED = 2'd2,
        PH_LEAVING  = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0]  id;
        logic [14:0] threshold;
    } t_slot_cfg;

    typedef struct packed {
        t_phase     phase;
        logic [5:0] count;
    } t_slot_dyn;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD_MUL,
        ST_LOAD_DIV,
        ST_LOAD_WR,
        ST_SCAN,
        ST_DRAIN,
        ST_RESULT
    } t_ctrl_state;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div;
        logic load_wr;
        logic scan_rd;
    } t_ctrl_cmd;

    typedef struct packed {
        logic in_eval;
        logic no_slots;
        logic scan_last;
    } t_dp_status;

endpackage

>>> src/rod_ctrl.sv
// rod_ctrl: sequencing state machine for load and evaluate transactions
// depends on rod_pkg; drives rod_datapath through t_ctrl_cmd
module rod_ctrl
    import rod_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    input  t_dp_status i_status,
    output t_ctrl_cmd  o_cmd,
    output logic       busy,
    output logic       o_done
);

    t_ctrl_state r_state;
    t_ctrl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = 1'b1;
        o_done  = 1'b0;
        case (r_state)
            ST_IDLE: begin
                busy = 1'b0;
                if (start) begin
                    o_cmd.capture = 1'b1;
                    if (i_status.in_eval == REQ_LOAD) begin
                        n_state = ST_LOAD_MUL;
                    end else if (i_status.no_slots) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_LOAD_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = ST_LOAD_DIV;
            end
            ST_LOAD_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = ST_LOAD_WR;
            end
            ST_LOAD_WR: begin
                o_cmd.load_wr = 1'b1;
                n_state       = ST_RESULT;
            end
            ST_SCAN: begin
                o_cmd.scan_rd = 1'b1;
                if (i_status.scan_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                n_state = ST_RESULT;
            end
            ST_RESULT: begin
                o_done  = 1'b1;
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

endmodule

>>> src/rod_datapath.sv
// rod_datapath: config registers, slot memories, threshold arithmetic and debounce step
// depends on rod_pkg; commanded by rod_ctrl
module rod_datapath
    import rod_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_ctrl_cmd  i_cmd,
    output t_dp_status o_status,
    input  t_req       i_req,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data,
    output t_result    o_result
);

    localparam int AW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW       = (AW > 6) ? AW : 6;
    localparam int SCAN_LIM = (SLOTS < 63) ? SLOTS : 63;

    logic [5:0] r_active;
    logic [5:0] r_limit;

    t_req        r_req;
    logic [15:0] r_size;
    logic [14:0] r_thr;
    logic [SW-1:0] r_scan;

    t_slot_cfg mem_cfg [SLOTS];
    t_slot_dyn mem_dyn [SLOTS];
    logic [SLOTS-1:0] r_vld;

    logic          r_pv;
    logic [AW-1:0] r_paddr;
    t_slot_cfg     r_rd_cfg;
    t_slot_dyn     r_rd_dyn;
    logic          r_rd_vld;

    logic       r_found;
    logic [2:0] r_rstate;

    logic [5:0]    n_active;
    logic [SW-1:0] n_scan_ext;
    logic [8:0]    load_idx;
    logic          load_ok;
    logic [16:0]   area;
    logic [31:0]   prod;
    logic [AW-1:0] scan_addr;

    t_slot_dyn cur;
    t_slot_dyn nxt;
    logic [15:0] thr16;
    logic        over_thr;
    logic        match;
    logic [5:0]  cnt_inc;

    // config port
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ACTIVE_SLOTS_RESET;
            r_limit  <= TRANSITION_LIMIT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_ACTIVE_SLOTS:     r_active <= i_cfg_data;
                CFG_TRANSITION_LIMIT: r_limit  <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign n_active   = (r_active > 6'(SCAN_LIM)) ? 6'(SCAN_LIM) : r_active;
    assign n_scan_ext = SW'(n_active);
    assign scan_addr  = r_scan[AW-1:0];

    assign o_status.in_eval   = i_req.req_type;
    assign o_status.no_slots  = (n_active == 6'd0);
    assign o_status.scan_last = (r_scan == (n_scan_ext - SW'(1)));

    // threshold arithmetic
    assign area     = 17'(r_req.region_width) * 17'(r_req.region_height);
    assign prod     = r_size * RECIP3;
    assign load_idx = 9'(r_req.slot_index);
    assign load_ok  = (load_idx < 9'(SLOTS));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_req <= i_req;
        end
        if (i_cmd.mul) begin
            r_size <= area[15:0];
        end
        if (i_cmd.div) begin
            r_thr <= prod[RECIP3_SHIFT +: 15];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_scan <= '0;
        end else if (i_cmd.scan_rd) begin
            r_scan <= r_scan + SW'(1);
        end
    end

    // slot memories
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_wr && load_ok) begin
            mem_cfg[load_idx[AW-1:0]] <= {r_req.region_number, r_thr};
        end
        if (i_cmd.scan_rd) begin
            r_rd_cfg <= mem_cfg[scan_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (match) begin
            mem_dyn[r_paddr] <= nxt;
        end
        if (i_cmd.scan_rd) begin
            r_rd_dyn <= mem_dyn[scan_addr];
            r_paddr  <= scan_addr;
        end
    end

    // valid bits stand for the reset value free with a zero counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_pv     <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_pv <= i_cmd.scan_rd;
            if (i_cmd.scan_rd) begin
                r_rd_vld <= r_vld[scan_addr];
            end
            if (i_cmd.load_wr && load_ok) begin
                r_vld[load_idx[AW-1:0]] <= 1'b0;
            end else if (match) begin
                r_vld[r_paddr] <= 1'b1;
            end
        end
    end

    // debounce step of the slot in write-back
    assign cur.phase = r_rd_vld ? r_rd_dyn.phase : PH_FREE;
    assign cur.count = r_rd_vld ? r_rd_dyn.count : 6'd0;
    assign thr16     = {1'b0, r_rd_cfg.threshold};
    assign over_thr  = (r_req.red_changed > thr16) || (r_req.green_changed > thr16)
                    || (r_req.blue_changed > thr16);
    assign match     = r_pv && (r_rd_cfg.id == r_req.region_number);
    assign cnt_inc   = (cur.count < COUNT_MAX) ? (cur.count + 6'd1) : cur.count;

    always_comb begin
        nxt = cur;
        case (cur.phase)
            PH_FREE: begin
                if (over_thr) begin
                    nxt.phase = PH_ENTERING;
                    nxt.count = 6'd0;
                end
            end
            PH_ENTERING: begin
                if (over_thr) begin
                    nxt.count = cnt_inc;
                    if (cnt_inc > r_limit) begin
                        nxt.phase = PH_OCCUPIED;
                        nxt.count = 6'd0;
                    end
                end else begin
                    nxt.phase = PH_FREE;
                    nxt.count = 6'd0;
                end
            end
            PH_OCCUPIED: begin
                if (!over_thr) begin
                    nxt.phase = PH_LEAVING;
                    nxt.count = 6'd0;
                end
            end
            PH_LEAVING: begin
                if (over_thr) begin
                    nxt.phase = PH_FREE;
                end else begin
                    nxt.count = cnt_inc;
                    if (cnt_inc > r_limit) begin
                        nxt.phase = PH_FREE;
                        nxt.count = 6'd0;
                    end
                end
            end
            default: begin
                nxt = cur;
            end
        endcase
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found  <= 1'b0;
            r_rstate <= STATE_NONE;
        end else if (i_cmd.capture) begin
            r_found  <= 1'b0;
            r_rstate <= STATE_NONE;
        end else if (match) begin
            r_found  <= 1'b1;
            r_rstate <= {1'b0, nxt.phase} + 3'd1;
        end
    end

    assign o_result.found        = r_found;
    assign o_result.region_state = r_rstate;

endmodule

>>> src/region_occupancy_debouncer_core.sv
// region_occupancy_debouncer_core: top level, one request at a time, result strobed on o_done
// load: two multiplies (width times height, then times the reciprocal of 3), slot write, then o_done
// evaluate: n = min(active_slots, SLOTS) slots are scanned, one slot read per cycle, then a drain
// state and o_done; with n at 0 the scan and drain are skipped; requests are not overlapped
// reset: active_slots 0, transition_limit 20, all slots free with zero counters at once;
// slot ids and thresholds undefined until loaded; the receiver cannot stall
module region_occupancy_debouncer_core
    import rod_pkg::*;
#(
    parameter int SLOTS = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       start,
    output logic       busy,
    input  t_req       i_req,
    output logic       o_done,
    output t_result    o_result,
    input  logic       i_cfg_we,
    input  logic       i_cfg_idx,
    input  logic [5:0] i_cfg_data
);

    t_ctrl_cmd  cmd;
    t_dp_status status;

    rod_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_status (status),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_done   (o_done)
    );

    rod_datapath #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .o_status   (status),
        .i_req      (i_req),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_result   (o_result)
    );

    a_done_while_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> busy)
        else $error("result strobe outside a transaction");

    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transaction did not raise busy");

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!busy && !o_done))
        else $error("busy held after result strobe");

    a_none_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_result.found) |-> (o_result.region_state == STATE_NONE))
        else $error("state reported without a match");

endmodule
